// ===== hdl/page_table_lru_fifo_translate_macros.svh =====
// Assertion macros shared by the page table translator RTL.
`ifndef PAGE_TABLE_LRU_FIFO_TRANSLATE_MACROS_SVH
`define PAGE_TABLE_LRU_FIFO_TRANSLATE_MACROS_SVH
`ifndef ASSERT_OFF
`define PTLF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PTLF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PTLF_ASSERT(lbl, cond, msg)
`define PTLF_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/ptlf_pkg.sv =====
// Shared types and constants of the page table translator.
package ptlf_pkg;
  localparam int VA_W = 31;
  localparam int PW_W = 17;
  localparam int FC_W = 5;
  localparam int PA_W = 20;
  localparam int FR_OUT_W = 4;
  localparam int MAX_FRAMES_DEF = 16;

  localparam logic [PW_W-1:0] PAGE_WORDS_RST = 17'd256;
  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 5'd16;
  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  typedef enum logic [1:0] {
    REG_PAGE_WORDS = 2'd0,
    REG_FRAME_COUNT = 2'd1,
    REG_POLICY = 2'd2,
    REG_NONE = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Per-cell control: live marks a resident entry, shift takes the right
  // neighbor's contents, load takes the broadcast page and frame.
  typedef struct packed {
    logic live;
    logic shift;
    logic load;
  } cell_ctl_t;
endpackage

// ===== hdl/page_table_lru_fifo_translate.sv =====
// Top level of the fully associative page table translator.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall    virtual_address
//  out      output     out_valid / out_stall  physical_address, fault, evicted, frame
//  cfg      input      cfg_write              cfg_index, cfg_data
//
// An accepted item first runs through the bit-serial divider that splits the
// address into page and offset. The controller then sees the divider finish,
// and the cell row is searched and updated and the result is registered. The
// block holds one item at a time: the next item is accepted only once the
// controller has returned to its idle state after the table update.
// Reset, and any write to a known register, empties the table through the fill
// count at once; no clearing pass is needed. The result waits in an output
// register while out_stall is high; the next item's table update waits until
// the output register is free, and no further item is accepted meanwhile.
`include "page_table_lru_fifo_translate_macros.svh"
module page_table_lru_fifo_translate #(
  parameter int MAX_FRAMES = ptlf_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptlf_pkg::VA_W-1:0]     virtual_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ptlf_pkg::PA_W-1:0]     physical_address,
  output logic                          fault,
  output logic                          evicted,
  output logic [ptlf_pkg::FR_OUT_W-1:0] frame,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [ptlf_pkg::PW_W-1:0]     cfg_data
);
  import ptlf_pkg::*;

  // Frame numbers and the fill count are sized by the table depth.
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  logic [PW_W-1:0] page_words;
  logic [FC_W-1:0] frame_count;
  logic policy;
  logic clear;

  state_t state;
  logic [CW-1:0] used;
  logic [CW-1:0] nf;
  logic in_accept;
  logic out_free;
  logic update;

  logic [PW_W-1:0] pw;
  logic div_done;
  logic [VA_W-1:0] vp;
  logic [PW_W-1:0] off;

  cell_ctl_t ctl [MAX_FRAMES];
  logic [VA_W-1:0] c_page [MAX_FRAMES];
  logic [FW-1:0] c_frame [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] c_match;

  logic hit;
  logic [FW-1:0] hit_idx;
  logic full;
  logic [VA_W-1:0] new_page;
  logic [FW-1:0] new_frame;
  logic [FW-1:0] res_frame;
  logic [PW_W+FW-1:0] product;

  assign in_accept = in_valid && !in_stall;
  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;
  assign update = (state == S_DONE) && out_free;

  // A page size of zero behaves as one word per page.
  assign pw = (page_words == '0) ? PW_W'(1) : page_words;

  // The frame count is held between one and the table depth.
  always_comb begin
    if (frame_count == '0) begin
      nf = CW'(1);
    end else if (int'(frame_count) > MAX_FRAMES) begin
      nf = CW'(MAX_FRAMES);
    end else begin
      nf = CW'(frame_count);
    end
  end

  assign clear = cfg_write && (reg_index_t'(cfg_index) != REG_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_words <= PAGE_WORDS_RST;
      frame_count <= FRAME_COUNT_RST;
      policy <= POLICY_LRU;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_PAGE_WORDS: page_words <= cfg_data;
        REG_FRAME_COUNT: frame_count <= cfg_data[FC_W-1:0];
        REG_POLICY: policy <= cfg_data[0];
        REG_NONE: ;
        default: ;
      endcase
    end
  end

  ptlf_div u_div (
    .clk(clk),
    .rst(rst),
    .start(in_accept),
    .dividend(virtual_address),
    .divisor(pw),
    .done(div_done),
    .quotient(vp),
    .remainder(off)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_accept) state <= S_DIV;
        S_DIV: if (div_done) state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Resident entries always sit in cells 0 .. used-1, so the fill count alone
  // says which cells are live. The first match among them is the hit.
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
      if (c_match[k]) begin
        hit = 1'b1;
        hit_idx = FW'(k);
      end
    end
  end

  assign full = used >= nf;

  // Broadcast value and result frame for the three cases: a hit returns the hit
  // entry itself, which under LRU is rotated to the tail, a fill takes the slot
  // number, an eviction reuses the head entry's frame for the new page.
  always_comb begin
    if (hit) begin
      new_page = c_page[hit_idx];
      new_frame = c_frame[hit_idx];
    end else if (!full) begin
      new_page = vp;
      new_frame = used[FW-1:0];
    end else begin
      new_page = vp;
      new_frame = c_frame[0];
    end
  end
  assign res_frame = new_frame;

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    always_comb begin
      ctl[k].live = k < int'(used);
      ctl[k].shift = 1'b0;
      ctl[k].load = 1'b0;
      if (update) begin
        if (hit) begin
          if (policy == POLICY_LRU) begin
            ctl[k].shift = (k >= int'(hit_idx)) && (k < int'(used) - 1);
            ctl[k].load = k == int'(used) - 1;
          end
        end else if (!full) begin
          ctl[k].load = k == int'(used);
        end else begin
          ctl[k].shift = k < int'(nf) - 1;
          ctl[k].load = k == int'(nf) - 1;
        end
      end
    end

    if (k == MAX_FRAMES - 1) begin : g_last
      ptlf_cell #(.FW(FW)) u_cell (
        .clk(clk),
        .ctl(ctl[k]),
        .key(vp),
        .nb_page('0),
        .nb_frame('0),
        .new_page(new_page),
        .new_frame(new_frame),
        .page(c_page[k]),
        .frame(c_frame[k]),
        .match(c_match[k])
      );
    end else begin : g_mid
      ptlf_cell #(.FW(FW)) u_cell (
        .clk(clk),
        .ctl(ctl[k]),
        .key(vp),
        .nb_page(c_page[k+1]),
        .nb_frame(c_frame[k+1]),
        .new_page(new_page),
        .new_frame(new_frame),
        .page(c_page[k]),
        .frame(c_frame[k]),
        .match(c_match[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      used <= '0;
    end else if (update && !hit && !full) begin
      used <= used + 1'b1;
    end
  end

  assign product = (PW_W+FW)'(pw) * (PW_W+FW)'(res_frame);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      physical_address <= PA_W'(PA_W'(product) + PA_W'(off));
      fault <= !hit;
      evicted <= !hit && full;
      frame <= FR_OUT_W'(res_frame);
    end
  end

  `PTLF_ASSERT(a_used_bound, used <= nf, "fill count past frame count")
  `PTLF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
  `PTLF_ASSERT_NEXT(a_start_div, in_accept, state == S_DIV, "divider not started")
  `PTLF_ASSERT_NEXT(a_update_out, update, out_valid, "update without result")
  `PTLF_ASSERT(a_hit_single, $onehot0(c_match), "page resident twice")
endmodule

// ===== hdl/ptlf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ptlf_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ptlf_pkg::VA_W-1:0] dividend,
  input  logic [ptlf_pkg::PW_W-1:0] divisor,
  output logic                     done,
  output logic [ptlf_pkg::VA_W-1:0] quotient,
  output logic [ptlf_pkg::PW_W-1:0] remainder
);
  import ptlf_pkg::*;

  localparam int CNT_W = $clog2(VA_W + 1);

  logic [CNT_W-1:0] count;
  logic [VA_W-1:0] quo;
  logic [PW_W-1:0] rem;
  logic [PW_W-1:0] dvs;
  logic [PW_W:0] trial;
  logic take;

  assign trial = {rem, quo[VA_W-1]};
  assign take = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(VA_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (count != '0) begin
      if (take) begin
        rem <= PW_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[PW_W-1:0];
      end
      quo <= {quo[VA_W-2:0], take};
    end
  end

  assign quotient = quo;
  assign remainder = rem;
endmodule

// ===== hdl/ptlf_cell.sv =====
// One table entry: holds a page and a frame, compares the page to the key.
module ptlf_cell #(
  parameter int FW = 4
) (
  input  logic                      clk,
  input  ptlf_pkg::cell_ctl_t       ctl,
  input  logic [ptlf_pkg::VA_W-1:0] key,
  input  logic [ptlf_pkg::VA_W-1:0] nb_page,
  input  logic [FW-1:0]             nb_frame,
  input  logic [ptlf_pkg::VA_W-1:0] new_page,
  input  logic [FW-1:0]             new_frame,
  output logic [ptlf_pkg::VA_W-1:0] page,
  output logic [FW-1:0]             frame,
  output logic                      match
);
  import ptlf_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      page <= new_page;
      frame <= new_frame;
    end else if (ctl.shift) begin
      page <= nb_page;
      frame <= nb_frame;
    end
  end

  assign match = ctl.live && (page == key);
endmodule
